FILE: hdl/hsba_pkg.sv
`timescale 1ns / 1ps

package hsba_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int PROBE_LIMIT  = 4;
  localparam int LOG2_MAX     = 4;

  localparam int POS_W   = 27;
  localparam int OFF_W   = 26;
  localparam int HASH_W  = 32;
  localparam int SEG_W   = 4;
  localparam int LOG2_W  = 3;
  localparam int CNT_W   = 32;
  localparam int NSEG_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LOG2  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_BYTES = 1'b1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SEG_W-1:0] seg_idx_t;
  typedef pos_t [MAX_SEGMENTS-1:0] pos_arr_t;

  typedef struct packed {
    logic [POS_W-1:0]  request_size;
    logic [HASH_W-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [SEG_W-1:0]  seg_index;
    logic [OFF_W-1:0]  byte_offset;
    logic              recycled;
    logic [CNT_W-1:0]  recycle_total;
  } out_item_t;

  typedef struct packed {
    logic     grant;
    logic     recycle;
    seg_idx_t seg_idx;
    pos_t     old_pos;
  } alloc_dec_t;

endpackage

FILE: hdl/hsba_probe.sv
`timescale 1ns / 1ps

module hsba_probe import hsba_pkg::*; (
  input  pos_arr_t            fill_pos,
  input  logic [LOG2_W-1:0]   seg_log2,
  input  pos_t                seg_bytes,
  input  in_item_t            req,
  output alloc_dec_t          dec
);

  logic [MAX_SEGMENTS-1:0] room;
  logic [LOG2_W-1:0]       lg;
  logic [NSEG_W-1:0]       nseg;
  logic [NSEG_W-1:0]       probes;
  seg_idx_t                mask;
  seg_idx_t                home;
  seg_idx_t                cur;
  seg_idx_t                s;
  logic                    found;
  logic                    grant;
  pos_t                    sel_pos;

  // room check for every segment in parallel
  always_comb begin
    for (int j = 0; j < MAX_SEGMENTS; j++) begin
      room[j] = (fill_pos[j] <= seg_bytes) &&
                ((seg_bytes - fill_pos[j]) >= req.request_size);
    end
  end

  always_comb begin
    lg     = (seg_log2 > LOG2_W'(LOG2_MAX)) ? LOG2_W'(LOG2_MAX) : seg_log2;
    nseg   = NSEG_W'(1) << lg;
    mask   = SEG_W'(nseg - NSEG_W'(1));
    probes = (nseg < NSEG_W'(PROBE_LIMIT)) ? nseg : NSEG_W'(PROBE_LIMIT);
    home   = req.hash_value[SEG_W-1:0] & mask;
    grant  = req.request_size <= seg_bytes;
    found  = 1'b0;
    cur    = home;
    s      = home;
    for (int i = 0; i < PROBE_LIMIT; i++) begin
      s = (home + SEG_W'(i)) & mask;
      if (!found && (NSEG_W'(i) < probes) && room[s]) begin
        found = 1'b1;
        cur   = s;
      end
    end
    if (!found) begin
      cur = (home + SEG_W'(probes - NSEG_W'(1))) & mask;
    end
    sel_pos = '0;
    for (int j = 0; j < MAX_SEGMENTS; j++) begin
      if (cur == SEG_W'(j)) begin
        sel_pos = sel_pos | fill_pos[j];
      end
    end
    dec.grant   = grant;
    dec.recycle = grant && !found;
    dec.seg_idx = grant ? cur : '0;
    dec.old_pos = (grant && found) ? sel_pos : '0;
  end

endmodule

FILE: hdl/hsba_state.sv
`timescale 1ns / 1ps

module hsba_state import hsba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd,
  input  alloc_dec_t       dec,
  input  pos_t             req_size,
  output pos_arr_t         fill_pos,
  output logic [CNT_W-1:0] recycle_count
);

  pos_arr_t         fill_r;
  pos_arr_t         fill_nxt;
  logic [CNT_W-1:0] rcnt_r;
  logic [CNT_W-1:0] rcnt_nxt;
  pos_t             new_pos;

  always_comb begin
    new_pos  = dec.old_pos + req_size;
    fill_nxt = fill_r;
    for (int j = 0; j < MAX_SEGMENTS; j++) begin
      if (upd && dec.grant && (dec.seg_idx == SEG_W'(j))) begin
        fill_nxt[j] = new_pos;
      end
    end
    rcnt_nxt = (upd && dec.recycle) ? rcnt_r + CNT_W'(1) : rcnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rcnt_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

  assign fill_pos      = fill_r;
  assign recycle_count = rcnt_r;

endmodule

FILE: hdl/hashed_segment_bump_allocator_core.sv
`timescale 1ns / 1ps
// channel   ports                       accepted when
// input     start, busy, in_data        rising edge with start high, busy low
// result    out_valid, out_data         rising edge ending the strobe cycle
// config    cfg_we, cfg_index, cfg_wdata rising edge with cfg_we high
//
// one item per cycle; busy is always low
// result strobe is registered after the item is taken (input reg, then result reg)
// fill positions live in flip-flops, all compared in one pass
// synchronous reset clears fill positions and recycle count and loads config defaults
// results are never stalled

module hashed_segment_bump_allocator_core import hsba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [LOG2_W-1:0] seg_log2_r;
  logic [LOG2_W-1:0] seg_log2_nxt;
  pos_t              seg_bytes_r;
  pos_t              seg_bytes_nxt;
  logic              in_valid_r;
  in_item_t          in_req_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;
  pos_arr_t          fill_pos;
  logic [CNT_W-1:0]  recycle_count;
  alloc_dec_t        dec;

  assign busy = 1'b0;

  always_comb begin
    seg_log2_nxt  = seg_log2_r;
    seg_bytes_nxt = seg_bytes_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEG_LOG2:  seg_log2_nxt  = cfg_wdata[LOG2_W-1:0];
        CFG_SEG_BYTES: seg_bytes_nxt = cfg_wdata[POS_W-1:0];
        default:       seg_log2_nxt  = seg_log2_r;
      endcase
    end
  end

  hsba_probe u_probe (
    .fill_pos  (fill_pos),
    .seg_log2  (seg_log2_r),
    .seg_bytes (seg_bytes_r),
    .req       (in_req_r),
    .dec       (dec)
  );

  hsba_state u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (in_valid_r),
    .dec           (dec),
    .req_size      (in_req_r.request_size),
    .fill_pos      (fill_pos),
    .recycle_count (recycle_count)
  );

  always_comb begin
    out_data_nxt.granted       = dec.grant;
    out_data_nxt.seg_index     = dec.seg_idx;
    out_data_nxt.byte_offset   = dec.old_pos[OFF_W-1:0];
    out_data_nxt.recycled      = dec.recycle;
    out_data_nxt.recycle_total = dec.recycle ? recycle_count + CNT_W'(1) : recycle_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_log2_r  <= LOG2_W'(4);
      seg_bytes_r <= POS_W'(4194304);
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seg_log2_r  <= seg_log2_nxt;
      seg_bytes_r <= seg_bytes_nxt;
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req_r <= in_data;
    end
    if (in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb_hashed_segment_bump_allocator_core.sv
`timescale 1ns / 1ps

module tb_hashed_segment_bump_allocator_core;
  import hsba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int unsigned SEG_MAX_BYTES = 32'h0400_0000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_data = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SEG_LOG2;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  hashed_segment_bump_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // allocator state as the testbench sees it
  pos_t              seg_fill [MAX_SEGMENTS];
  logic [CNT_W-1:0]  recycle_cnt;
  logic [LOG2_W-1:0] cfg_log2;
  pos_t              cfg_seg_bytes;

  out_item_t expected_results[$];

  int n_requests, n_granted, n_rejected, n_recycles, n_errors;
  int n_log2_writes, n_bytes_writes;
  int idle_cycles;
  int burst_left;
  bit start_hi;

  function automatic bit seg_has_room(int unsigned seg, int unsigned size);
    int unsigned pos;
    int unsigned cap;
    pos = seg_fill[seg];
    cap = cfg_seg_bytes;
    return (pos <= cap) && ((cap - pos) >= size);
  endfunction

  function automatic out_item_t predict_alloc(in_item_t req);
    out_item_t   res;
    int unsigned n, mask, probes, home, seg, pick, size;
    bit          found;
    pos_t        old_pos;
    res = '0;
    size = req.request_size;
    if (size > cfg_seg_bytes) begin
      res.recycle_total = recycle_cnt;
      return res;
    end
    n = 1 << cfg_log2;
    while (n > 1 && n > MAX_SEGMENTS) n = n >> 1;
    mask = n - 1;
    probes = (n < PROBE_LIMIT) ? n : PROBE_LIMIT;
    home = req.hash_value & mask;
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < probes; i++) begin
      seg = (home + i) & mask;
      if (!found && seg_has_room(seg, size)) begin
        pick = seg;
        found = 1'b1;
      end
    end
    if (!found) begin
      pick = (home + probes - 1) & mask;
      seg_fill[pick] = '0;
      recycle_cnt = recycle_cnt + 1;
      res.recycled = 1'b1;
    end
    old_pos = seg_fill[pick];
    seg_fill[pick] = old_pos + pos_t'(size);
    res.granted = 1'b1;
    res.seg_index = pick[SEG_W-1:0];
    res.byte_offset = old_pos[OFF_W-1:0];
    res.recycle_total = recycle_cnt;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit        progress;
    progress = 1'b0;
    if (!rst_n) begin
      foreach (seg_fill[i]) seg_fill[i] = '0;
      recycle_cnt = '0;
      cfg_log2 = 3'd4;
      cfg_seg_bytes = 27'd4194304;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEG_LOG2) cfg_log2 = cfg_wdata[LOG2_W-1:0];
        else cfg_seg_bytes = cfg_wdata;
      end
      if (start && !busy) begin
        expected_results.push_back(predict_alloc(in_data));
        n_requests++;
        progress = 1'b1;
      end
      if (out_valid) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("granted", want.granted, out_data.granted);
          check_field("seg_index", want.seg_index, out_data.seg_index);
          check_field("byte_offset", want.byte_offset, out_data.byte_offset);
          check_field("recycled", want.recycled, out_data.recycled);
          check_field("recycle_total", want.recycle_total, out_data.recycle_total);
          if (want.granted) n_granted++;
          else n_rejected++;
          if (want.recycled) n_recycles++;
        end
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [POS_W-1:0] size, input logic [HASH_W-1:0] hash);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(80, 40) : $urandom_range(20, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0 && start_hi) begin
        start <= 1'b0;
        start_hi = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    start_hi = 1'b1;
    in_data <= '{request_size: size, hash_value: hash};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_idle();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    if (idx == CFG_SEG_LOG2) n_log2_writes++;
    else n_bytes_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_config();
    send_item(27'd0, 32'h0);
    send_item(27'd4194304, 32'h0);
    send_item(27'd1, 32'h10);
    send_item(27'd4194305, 32'hFFFF_FFFF);
    send_item(27'h7FF_FFFF, 32'hFFFF_FFFF);
    send_item(27'd0, 32'hFFFF_FFF0);
  endtask

  // one segment, full capacity, offset wrap on a zero-size item at the top
  task automatic test_single_segment();
    write_reg(CFG_SEG_LOG2, 0);
    write_reg(CFG_SEG_BYTES, SEG_MAX_BYTES);
    send_item(pos_t'(SEG_MAX_BYTES), $urandom());
    send_item(27'd0, $urandom());
    send_item(27'd1, $urandom());
    send_item(pos_t'(SEG_MAX_BYTES + 1), $urandom());
  endtask

  task automatic test_probe_wrap_and_recycle();
    write_reg(CFG_SEG_LOG2, 2);
    write_reg(CFG_SEG_BYTES, 16);
    send_item(27'd16, 32'h3);
    send_item(27'd8, 32'h3);
    send_item(27'd8, 32'h0);
    send_item(27'd16, 32'h1);
    send_item(27'd16, 32'h2);
    send_item(27'd1, 32'h2);
  endtask

  task automatic test_short_ring();
    write_reg(CFG_SEG_LOG2, 1);
    write_reg(CFG_SEG_BYTES, 4);
    send_item(27'd4, 32'h0);
    send_item(27'd4, 32'h1);
    send_item(27'd4, 32'h0);
  endtask

  task automatic test_oversized_count();
    write_reg(CFG_SEG_LOG2, 7);
    write_reg(CFG_SEG_BYTES, 2);
    send_item(27'd2, 32'h1F);
    send_item(27'd2, 32'h1F);
    send_item(27'd1, 32'h5);
    write_reg(CFG_SEG_LOG2, 5);
    send_item(27'd0, 32'hA);
  endtask

  task automatic test_capacity_lowered();
    write_reg(CFG_SEG_LOG2, 4);
    write_reg(CFG_SEG_BYTES, 100);
    send_item(27'd90, 32'h3);
    write_reg(CFG_SEG_BYTES, 50);
    send_item(27'd1, 32'h3);
  endtask

  function automatic logic [POS_W-1:0] pick_size(int unsigned cap);
    case ($urandom_range(9))
      0: return POS_W'($urandom_range(32'h7FF_FFFF));
      1: return POS_W'(cap);
      2: return '0;
      3: return POS_W'(cap + $urandom_range(16, 1));
      default: return POS_W'($urandom_range(cap / 3 + 1));
    endcase
  endfunction

  task automatic test_random_traffic(input int unsigned log2, input int unsigned cap,
                                     input int count);
    logic [HASH_W-1:0] hash;
    write_reg(CFG_SEG_LOG2, log2);
    write_reg(CFG_SEG_BYTES, cap);
    repeat (count) begin
      hash = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom();
      send_item(pick_size(cap), hash);
      if ($urandom_range(199) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_config();
    test_single_segment();
    test_probe_wrap_and_recycle();
    test_short_ring();
    test_oversized_count();
    test_capacity_lowered();

    test_random_traffic(4, 4194304, 128);
    test_random_traffic(0, 1, 128);
    test_random_traffic(1, 37, 128);
    test_random_traffic(2, 256, 128);
    test_random_traffic(7, 4096, 128);
    test_random_traffic(3, SEG_MAX_BYTES, 128);
    test_random_traffic(6, 1000, 128);
    test_random_traffic(5, 12, 128);

    wait_idle();
    repeat (5) @(posedge clk);

    $display("run covered %0d requests: %0d granted, %0d rejected, %0d with recycle",
             n_requests, n_granted, n_rejected, n_recycles);
    $display("segment count set %0d times, segment capacity set %0d times",
             n_log2_writes, n_bytes_writes);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
